/* hw/rtl/assert_macros.svh */
// Assertion helpers, clocked on aclk and dropped while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define DGIF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define DGIF_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`endif

/* hw/rtl/dgif_pkg.sv */
`timescale 1ns / 1ps

package dgif_pkg;

    localparam int DEF_MAX_X_BINS = 128;
    localparam int DEF_MAX_Y_BINS = 32;
    localparam int DEF_MAX_Z_BINS = 32;
    localparam int DEF_COUNT_BITS = 16;

    localparam int POS_BITS  = 16;
    localparam int THR_BITS  = 24;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int S_DATA_W  = 64;
    localparam int S_USER_W  = 2;
    localparam int M_DATA_W  = 40;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_QUERY = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        CFG_BW_X    = 3'd0,
        CFG_BW_Y    = 3'd1,
        CFG_BW_Z    = 3'd2,
        CFG_SURFACE = 3'd3,
        CFG_THRESH  = 3'd4,
        CFG_NX      = 3'd5,
        CFG_NY      = 3'd6,
        CFG_NZ      = 3'd7
    } cfg_reg_t;

    typedef enum logic [2:0] {
        DS_X,
        DS_Y,
        DS_Z,
        DS_L,
        DS_R
    } div_sel_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_ADD_CHK,
        S_DIV_GO,
        S_DIV_WAIT,
        S_ADD_BND,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_CHK,
        S_Q_RD,
        S_Q_EV,
        S_Q_POST,
        S_MUL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     clr_init;
        logic     clr_step;
        logic     load;
        logic     set_drop;
        logic     div_start;
        logic     add_rd;
        logic     add_wr;
        logic     scan_init;
        logic     scan_rd;
        logic     scan_ev;
        logic     mul_go;
        logic     out_load;
        div_sel_t dsel;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_code_t cmd;
        logic      clr_last;
        logic      below;
        logic      add_oob;
        logic      cnt_full;
        logic      q_skip;
        logic      scan_last;
        logic      left_found;
        logic      right_found;
        logic      div_done;
        logic      out_free;
    } dp_status_t;

endpackage

/* hw/rtl/dgif_divider.sv */
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle; quotient known to fit 16 bits
module dgif_divider #(
    parameter int DSW = 24
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic [DSW+dgif_pkg::POS_BITS-1:0] dividend,
    input  logic [DSW-1:0]                    divisor,
    output logic                              done,
    output logic [dgif_pkg::POS_BITS-1:0]     quot,
    output logic                              rem_nz
);

    localparam int QW = dgif_pkg::POS_BITS;
    localparam int CW = $clog2(QW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DSW-1:0] rem_reg, rem_next;
    logic [QW-1:0] low_reg, low_next;
    logic [QW-1:0] quot_reg, quot_next;

    logic [DSW:0] trial;
    logic [DSW:0] diff;
    logic         ge;

    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = trial >= {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(QW);
            rem_next  = dividend[DSW+QW-1:QW];
            low_next  = dividend[QW-1:0];
            quot_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? diff[DSW-1:0] : trial[DSW-1:0];
            low_next  = {low_reg[QW-2:0], 1'b0};
            quot_next = {quot_reg[QW-2:0], ge};
            cnt_next  = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
    end

    assign done   = done_reg;
    assign quot   = quot_reg;
    assign rem_nz = |rem_reg;

endmodule

/* hw/rtl/dgif_datapath.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dgif_datapath #(
    parameter int MAX_X_BINS = dgif_pkg::DEF_MAX_X_BINS,
    parameter int MAX_Y_BINS = dgif_pkg::DEF_MAX_Y_BINS,
    parameter int MAX_Z_BINS = dgif_pkg::DEF_MAX_Z_BINS,
    parameter int COUNT_BITS = dgif_pkg::DEF_COUNT_BITS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dgif_pkg::ctrl_cmd_t               cmd,
    output dgif_pkg::dp_status_t              status,
    input  logic [dgif_pkg::S_DATA_W-1:0]     s_tdata,
    input  logic [dgif_pkg::S_USER_W-1:0]     s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dgif_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    input  logic [dgif_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dgif_pkg::CFG_DAT_W-1:0]    cfg_data
);

    localparam int PB   = dgif_pkg::POS_BITS;
    localparam int XW   = (MAX_X_BINS > 1) ? $clog2(MAX_X_BINS) : 1;
    localparam int YW   = (MAX_Y_BINS > 1) ? $clog2(MAX_Y_BINS) : 1;
    localparam int ZW   = (MAX_Z_BINS > 1) ? $clog2(MAX_Z_BINS) : 1;
    localparam int NXW  = $clog2(MAX_X_BINS + 1);
    localparam int NYW  = $clog2(MAX_Y_BINS + 1);
    localparam int NZW  = $clog2(MAX_Z_BINS + 1);
    localparam int MAW  = XW + YW + ZW;
    localparam int AW   = COUNT_BITS + 8;
    localparam int TW   = (AW > dgif_pkg::THR_BITS) ? AW : dgif_pkg::THR_BITS;
    localparam int PW   = PB + AW;
    localparam int KW   = XW + PB;
    localparam int SW   = XW + PB + 1;

    // configuration
    logic [PB-1:0] bwx_reg, bwy_reg, bwz_reg, surf_reg;
    logic [dgif_pkg::THR_BITS-1:0] thr_reg;
    logic [7:0] nx_reg;
    logic [5:0] ny_reg, nz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bwx_reg  <= PB'(128);
            bwy_reg  <= PB'(512);
            bwz_reg  <= PB'(333);
            surf_reg <= '0;
            thr_reg  <= dgif_pkg::THR_BITS'(508);
            nx_reg   <= 8'd128;
            ny_reg   <= 6'd32;
            nz_reg   <= 6'd32;
        end else if (cfg_valid) begin
            unique case (dgif_pkg::cfg_reg_t'(cfg_index))
                dgif_pkg::CFG_BW_X:    bwx_reg  <= cfg_data[PB-1:0];
                dgif_pkg::CFG_BW_Y:    bwy_reg  <= cfg_data[PB-1:0];
                dgif_pkg::CFG_BW_Z:    bwz_reg  <= cfg_data[PB-1:0];
                dgif_pkg::CFG_SURFACE: surf_reg <= cfg_data[PB-1:0];
                dgif_pkg::CFG_THRESH:  thr_reg  <= cfg_data;
                dgif_pkg::CFG_NX:      nx_reg   <= cfg_data[7:0];
                dgif_pkg::CFG_NY:      ny_reg   <= cfg_data[5:0];
                dgif_pkg::CFG_NZ:      nz_reg   <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [PB-1:0]  bwx_eff, bwy_eff, bwz_eff;
    logic [NXW-1:0] nx_eff, centre;
    logic [NYW-1:0] ny_eff;
    logic [NZW-1:0] nz_eff;

    assign bwx_eff = (bwx_reg == '0) ? PB'(1) : bwx_reg;
    assign bwy_eff = (bwy_reg == '0) ? PB'(1) : bwy_reg;
    assign bwz_eff = (bwz_reg == '0) ? PB'(1) : bwz_reg;
    assign nx_eff  = (32'(nx_reg) > MAX_X_BINS) ? NXW'(MAX_X_BINS) : NXW'(nx_reg);
    assign ny_eff  = (32'(ny_reg) > MAX_Y_BINS) ? NYW'(MAX_Y_BINS) : NYW'(ny_reg);
    assign nz_eff  = (32'(nz_reg) > MAX_Z_BINS) ? NZW'(MAX_Z_BINS) : NZW'(nz_reg);
    assign centre  = nx_eff >> 1;

    // captured beat
    dgif_pkg::cmd_code_t cmd_reg;
    logic [PB-1:0] px_reg, py_reg, pz_reg;
    logic [4:0]    qy_reg, qz_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg <= dgif_pkg::cmd_code_t'(s_tuser);
            px_reg  <= s_tdata[15:0];
            py_reg  <= s_tdata[31:16];
            pz_reg  <= s_tdata[47:32];
            qy_reg  <= s_tdata[52:48];
            qz_reg  <= s_tdata[57:53];
        end
    end

    // shared divider
    logic [PW-1:0] div_dividend;
    logic [AW-1:0] div_divisor;
    logic          div_done, div_rem_nz;
    logic [PB-1:0] div_quot;

    logic [PW-1:0] prod_reg;
    logic [KW-1:0] kbw_reg;
    logic [AW-1:0] den_reg;

    always_comb begin
        case (cmd.dsel)
            dgif_pkg::DS_X: begin
                div_dividend = PW'(px_reg);
                div_divisor  = AW'(bwx_eff);
            end
            dgif_pkg::DS_Y: begin
                div_dividend = PW'(py_reg);
                div_divisor  = AW'(bwy_eff);
            end
            dgif_pkg::DS_Z: begin
                div_dividend = PW'(pz_reg - surf_reg);
                div_divisor  = AW'(bwz_eff);
            end
            default: begin
                div_dividend = prod_reg;
                div_divisor  = den_reg;
            end
        endcase
    end

    dgif_divider #(.DSW(AW)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem_nz   (div_rem_nz)
    );

    logic [PB-1:0] bx_reg, by_reg, bz_reg;

    // counter store
    logic [COUNT_BITS-1:0] mem [2**MAW];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [MAW-1:0]        clr_addr_reg;
    logic [MAW-1:0]        mem_addr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic                  mem_we;
    logic [XW-1:0]         sx_reg;
    logic                  full;

    assign full = &rd_data_reg;

    always_comb begin
        mem_addr  = {YW'(by_reg), ZW'(bz_reg), XW'(bx_reg)};
        mem_wdata = rd_data_reg + COUNT_BITS'(1);
        mem_we    = cmd.add_wr && !full;
        if (cmd.clr_step) begin
            mem_addr  = clr_addr_reg;
            mem_wdata = '0;
            mem_we    = 1'b1;
        end else if (cmd.scan_rd) begin
            mem_addr = {YW'(qy_reg), ZW'(qz_reg), sx_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_init) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + MAW'(1);
        end
    end

    // column scan
    logic [COUNT_BITS-1:0] prev_reg;
    logic                  lf_reg, rf_reg;
    logic [XW-1:0]         lk_reg, rk_reg;
    logic [AW-1:0]         la_reg, lb_reg, ra_reg, rb_reg;
    logic [AW-1:0]         cur_a, prev_a;
    logic                  cur_hi, prev_hi;
    logic                  in_left, in_right;

    assign cur_a    = {rd_data_reg, 8'd0};
    assign prev_a   = {prev_reg, 8'd0};
    assign cur_hi   = TW'(cur_a) >= TW'(thr_reg);
    assign prev_hi  = TW'(prev_a) >= TW'(thr_reg);
    assign in_left  = (sx_reg != '0) && (32'(sx_reg) < 32'(centre));
    assign in_right = 32'(sx_reg) > 32'(centre);

    always_ff @(posedge aclk) begin
        if (cmd.scan_init) begin
            sx_reg <= '0;
            lf_reg <= 1'b0;
            rf_reg <= 1'b0;
        end else if (cmd.scan_ev) begin
            sx_reg   <= sx_reg + XW'(1);
            prev_reg <= rd_data_reg;
            if (in_left && !lf_reg && cur_hi && !prev_hi) begin
                lf_reg <= 1'b1;
                lk_reg <= sx_reg;
                la_reg <= cur_a;
                lb_reg <= prev_a;
            end
            if (in_right && prev_hi && !cur_hi) begin
                rf_reg <= 1'b1;
                rk_reg <= sx_reg - XW'(1);
                ra_reg <= prev_a;
                rb_reg <= cur_a;
            end
        end
    end

    // interpolation operands
    logic          side_l;
    logic [AW-1:0] sel_a, sel_b;
    logic [XW-1:0] sel_k;
    logic [TW-1:0] num_w;

    assign side_l = cmd.dsel == dgif_pkg::DS_L;
    assign sel_a  = side_l ? la_reg : ra_reg;
    assign sel_b  = side_l ? lb_reg : rb_reg;
    assign sel_k  = side_l ? lk_reg : rk_reg;
    assign num_w  = TW'(sel_a) - TW'(thr_reg);

    always_ff @(posedge aclk) begin
        if (cmd.mul_go) begin
            prod_reg <= PW'(bwx_eff) * PW'(num_w[AW-1:0]);
            kbw_reg  <= KW'(sel_k) * KW'(bwx_eff);
            den_reg  <= sel_a - sel_b;
        end
    end

    logic [SW-1:0] lpos_w, rpos_w;
    logic [PB-1:0] lpos_sat, rpos_sat;

    assign lpos_w   = SW'(kbw_reg) - SW'(div_quot) - SW'(div_rem_nz);
    assign rpos_w   = SW'(kbw_reg) + SW'(div_quot);
    assign lpos_sat = (lpos_w > SW'(16'hFFFF)) ? 16'hFFFF : lpos_w[PB-1:0];
    assign rpos_sat = (rpos_w > SW'(16'hFFFF)) ? 16'hFFFF : rpos_w[PB-1:0];

    // result
    logic          res_drop, res_lv, res_rv;
    logic [PB-1:0] res_lp, res_rp;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_drop <= 1'b0;
            res_lv   <= 1'b0;
            res_rv   <= 1'b0;
            res_lp   <= '0;
            res_rp   <= '0;
        end else begin
            if (cmd.set_drop || (cmd.add_wr && full)) begin
                res_drop <= 1'b1;
            end
            if (div_done) begin
                case (cmd.dsel)
                    dgif_pkg::DS_X: bx_reg <= div_quot;
                    dgif_pkg::DS_Y: by_reg <= div_quot;
                    dgif_pkg::DS_Z: bz_reg <= div_quot;
                    dgif_pkg::DS_L: begin
                        res_lv <= 1'b1;
                        res_lp <= lpos_sat;
                    end
                    default: begin
                        res_rv <= 1'b1;
                        res_rp <= rpos_sat;
                    end
                endcase
            end
        end
    end

    logic                              out_valid_reg;
    logic [dgif_pkg::M_DATA_W-1:0]     out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.out_load) begin
            out_data_reg <= {5'd0, res_rp, res_rv, res_lp, res_lv, res_drop};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign status.cmd         = cmd_reg;
    assign status.clr_last    = &clr_addr_reg;
    assign status.below       = pz_reg < surf_reg;
    assign status.add_oob     = (32'(bx_reg) >= 32'(nx_eff)) || (32'(by_reg) >= 32'(ny_eff))
                                || (32'(bz_reg) >= 32'(nz_eff));
    assign status.cnt_full    = full;
    assign status.q_skip      = (32'(qy_reg) >= 32'(ny_eff)) || (32'(qz_reg) >= 32'(nz_eff))
                                || (nx_eff < NXW'(2));
    assign status.scan_last   = 32'(sx_reg) + 32'd1 == 32'(nx_eff);
    assign status.left_found  = lf_reg;
    assign status.right_found = rf_reg;
    assign status.div_done    = div_done;
    assign status.out_free    = !out_valid_reg || m_tready;

    `DGIF_ASSERT(a_no_overwrite, aclk, aresetn, cmd.out_load |-> (!out_valid_reg || m_tready), "result overwritten")
    `DGIF_NEVER(a_drop_excl, aclk, aresetn, out_valid_reg && out_data_reg[0] && (out_data_reg[1] || out_data_reg[18]), "drop with crossing")
    `DGIF_ASSERT(a_scan_range, aclk, aresetn, cmd.scan_ev |-> (32'(sx_reg) < 32'(nx_eff)), "scan past column")

endmodule

/* hw/rtl/dgif_ctrl.sv */
`timescale 1ns / 1ps

module dgif_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  dgif_pkg::dp_status_t status,
    output dgif_pkg::ctrl_cmd_t  cmd
);

    dgif_pkg::state_t   state_reg, state_next;
    dgif_pkg::div_sel_t dsel_reg, dsel_next;
    logic               clr_cmd_reg, clr_cmd_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dgif_pkg::S_CLR;
            dsel_reg    <= dgif_pkg::DS_X;
            clr_cmd_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            dsel_reg    <= dsel_next;
            clr_cmd_reg <= clr_cmd_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        dsel_next    = dsel_reg;
        clr_cmd_next = clr_cmd_reg;
        unique case (state_reg)
            dgif_pkg::S_CLR: begin
                if (status.clr_last) begin
                    state_next = clr_cmd_reg ? dgif_pkg::S_DONE : dgif_pkg::S_IDLE;
                end
            end
            dgif_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    state_next = dgif_pkg::S_ADD_CHK;
                end
            end
            dgif_pkg::S_ADD_CHK: begin
                unique case (status.cmd)
                    dgif_pkg::CMD_CLEAR: begin
                        clr_cmd_next = 1'b1;
                        state_next   = dgif_pkg::S_CLR;
                    end
                    dgif_pkg::CMD_ADD: begin
                        if (status.below) begin
                            state_next = dgif_pkg::S_DONE;
                        end else begin
                            dsel_next  = dgif_pkg::DS_X;
                            state_next = dgif_pkg::S_DIV_GO;
                        end
                    end
                    dgif_pkg::CMD_QUERY: state_next = dgif_pkg::S_Q_CHK;
                    default:             state_next = dgif_pkg::S_DONE;
                endcase
            end
            dgif_pkg::S_DIV_GO: state_next = dgif_pkg::S_DIV_WAIT;
            dgif_pkg::S_DIV_WAIT: begin
                if (status.div_done) begin
                    unique case (dsel_reg)
                        dgif_pkg::DS_X: begin
                            dsel_next  = dgif_pkg::DS_Y;
                            state_next = dgif_pkg::S_DIV_GO;
                        end
                        dgif_pkg::DS_Y: begin
                            dsel_next  = dgif_pkg::DS_Z;
                            state_next = dgif_pkg::S_DIV_GO;
                        end
                        dgif_pkg::DS_Z: state_next = dgif_pkg::S_ADD_BND;
                        dgif_pkg::DS_L: begin
                            if (status.right_found) begin
                                dsel_next  = dgif_pkg::DS_R;
                                state_next = dgif_pkg::S_MUL;
                            end else begin
                                state_next = dgif_pkg::S_DONE;
                            end
                        end
                        default: state_next = dgif_pkg::S_DONE;
                    endcase
                end
            end
            dgif_pkg::S_ADD_BND: begin
                state_next = status.add_oob ? dgif_pkg::S_DONE : dgif_pkg::S_ADD_RD;
            end
            dgif_pkg::S_ADD_RD: state_next = dgif_pkg::S_ADD_WR;
            dgif_pkg::S_ADD_WR: state_next = dgif_pkg::S_DONE;
            dgif_pkg::S_Q_CHK: begin
                state_next = status.q_skip ? dgif_pkg::S_DONE : dgif_pkg::S_Q_RD;
            end
            dgif_pkg::S_Q_RD: state_next = dgif_pkg::S_Q_EV;
            dgif_pkg::S_Q_EV: begin
                state_next = status.scan_last ? dgif_pkg::S_Q_POST : dgif_pkg::S_Q_RD;
            end
            dgif_pkg::S_Q_POST: begin
                if (status.left_found) begin
                    dsel_next  = dgif_pkg::DS_L;
                    state_next = dgif_pkg::S_MUL;
                end else if (status.right_found) begin
                    dsel_next  = dgif_pkg::DS_R;
                    state_next = dgif_pkg::S_MUL;
                end else begin
                    state_next = dgif_pkg::S_DONE;
                end
            end
            dgif_pkg::S_MUL: state_next = dgif_pkg::S_DIV_GO;
            dgif_pkg::S_DONE: begin
                if (status.out_free) begin
                    clr_cmd_next = 1'b0;
                    state_next   = dgif_pkg::S_IDLE;
                end
            end
            default: state_next = dgif_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.dsel = dsel_reg;
        s_tready = 1'b0;
        unique case (state_reg)
            dgif_pkg::S_CLR:      cmd.clr_step = 1'b1;
            dgif_pkg::S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            dgif_pkg::S_ADD_CHK: begin
                cmd.clr_init = status.cmd == dgif_pkg::CMD_CLEAR;
                cmd.set_drop = (status.cmd == dgif_pkg::CMD_ADD) && status.below;
            end
            dgif_pkg::S_DIV_GO:   cmd.div_start = 1'b1;
            dgif_pkg::S_ADD_BND:  cmd.set_drop  = status.add_oob;
            dgif_pkg::S_ADD_RD:   cmd.add_rd    = 1'b1;
            dgif_pkg::S_ADD_WR:   cmd.add_wr    = 1'b1;
            dgif_pkg::S_Q_CHK:    cmd.scan_init = 1'b1;
            dgif_pkg::S_Q_RD:     cmd.scan_rd   = 1'b1;
            dgif_pkg::S_Q_EV:     cmd.scan_ev   = 1'b1;
            dgif_pkg::S_MUL:      cmd.mul_go    = 1'b1;
            dgif_pkg::S_DONE:     cmd.out_load  = status.out_free;
            default: ;
        endcase
    end

endmodule

/* hw/rtl/density_grid_interface_finder_unit.sv */
`timescale 1ns / 1ps
// Clear: every counter of the store is zeroed, one counter a cycle.
// Add: three 16-step passes of the shared divider, then a counter read and write.
// Query: the column scan reads the store and then evaluates each column in turn,
// plus a multiply and an interpolation divide for each crossing found.
// One beat in flight at a time; the output register frees the input side early.
// Reset (synchronous, aresetn low) loads register defaults, then a clearing pass over the counter store.
module density_grid_interface_finder_unit #(
    parameter int MAX_X_BINS = dgif_pkg::DEF_MAX_X_BINS,
    parameter int MAX_Y_BINS = dgif_pkg::DEF_MAX_Y_BINS,
    parameter int MAX_Z_BINS = dgif_pkg::DEF_MAX_Z_BINS,
    parameter int COUNT_BITS = dgif_pkg::DEF_COUNT_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // pos_x[15:0] pos_y[31:16] pos_z[47:32] query_y[52:48] query_z[57:53]
    input  logic [dgif_pkg::S_DATA_W-1:0]  s_tdata,
    // cmd[1:0]
    input  logic [dgif_pkg::S_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // dropped[0] left_valid[1] left_position[17:2] right_valid[18] right_position[34:19]
    output logic [dgif_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [dgif_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dgif_pkg::CFG_DAT_W-1:0] cfg_data
);

    dgif_pkg::ctrl_cmd_t  cmd;
    dgif_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    dgif_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dgif_datapath #(
        .MAX_X_BINS (MAX_X_BINS),
        .MAX_Y_BINS (MAX_Y_BINS),
        .MAX_Z_BINS (MAX_Z_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

/* verif/density_grid_interface_finder_unit_chk.sv */
`timescale 1ns / 1ps

module density_grid_interface_finder_unit_chk (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [dgif_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [dgif_pkg::S_USER_W-1:0]    s_tuser,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [dgif_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [dgif_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dgif_pkg::CFG_DAT_W-1:0]   cfg_data,
    output int                               fail_count,
    output int                               pending,
    output int                               checked,
    output int                               crossings
);

    localparam int NXM = dgif_pkg::DEF_MAX_X_BINS;
    localparam int NYM = dgif_pkg::DEF_MAX_Y_BINS;
    localparam int NZM = dgif_pkg::DEF_MAX_Z_BINS;
    localparam int CELL_COUNT = NXM * NYM * NZM;

    typedef struct {
        bit          dropped;
        bit          left_valid;
        bit [15:0]   left_position;
        bit          right_valid;
        bit [15:0]   right_position;
    } grid_result_t;

    bit [dgif_pkg::DEF_COUNT_BITS-1:0] cell_count [0:CELL_COUNT-1];
    bit [15:0] bw_x, bw_y, bw_z, surface;
    bit [23:0] threshold;
    bit [7:0]  nx_reg;
    bit [5:0]  ny_reg, nz_reg;

    grid_result_t column_results[$];

    function automatic longint eff_w(bit [15:0] w);
        return (w == 0) ? 1 : longint'(w);
    endfunction

    function automatic int eff_n(int n, int mx);
        return (n > mx) ? mx : n;
    endfunction

    function automatic bit [15:0] sat16(longint v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    function automatic grid_result_t bin_or_scan(dgif_pkg::cmd_code_t cmd,
                                                 logic [dgif_pkg::S_DATA_W-1:0] d);
        grid_result_t r;
        int nx, ny, nz, centre, base, ci;
        longint px, py, pz, bx, by, bz, bw, a, b, num, den, thr;
        r = '{default: 0};
        nx = eff_n(nx_reg, NXM);
        ny = eff_n(ny_reg, NYM);
        nz = eff_n(nz_reg, NZM);
        bw = eff_w(bw_x);
        thr = threshold;
        case (cmd)
            dgif_pkg::CMD_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++) cell_count[i] = '0;
            end
            dgif_pkg::CMD_ADD: begin
                px = d[15:0];
                py = d[31:16];
                pz = d[47:32];
                if (pz < surface) begin
                    r.dropped = 1;
                end else begin
                    bx = px / bw;
                    by = py / eff_w(bw_y);
                    bz = (pz - surface) / eff_w(bw_z);
                    if (bx >= nx || by >= ny || bz >= nz) begin
                        r.dropped = 1;
                    end else begin
                        ci = int'((by * NZM + bz) * NXM + bx);
                        if (&cell_count[ci]) r.dropped = 1;
                        else cell_count[ci] = cell_count[ci] + 1'b1;
                    end
                end
            end
            dgif_pkg::CMD_QUERY: begin
                if (d[52:48] < ny && d[57:53] < nz) begin
                    centre = nx / 2;
                    base = (int'(d[52:48]) * NZM + int'(d[57:53])) * NXM;
                    for (int k = centre - 1; k >= 1; k--) begin
                        a = longint'(cell_count[base + k]) << 8;
                        b = longint'(cell_count[base + k - 1]) << 8;
                        if (a >= thr && b < thr) begin
                            num = a - thr;
                            den = a - b;
                            r.left_valid = 1;
                            r.left_position = sat16(k * bw - (bw * num + den - 1) / den);
                        end
                    end
                    for (int k = centre; k + 1 < nx; k++) begin
                        a = longint'(cell_count[base + k]) << 8;
                        b = longint'(cell_count[base + k + 1]) << 8;
                        if (a >= thr && b < thr) begin
                            num = a - thr;
                            den = a - b;
                            r.right_valid = 1;
                            r.right_position = sat16(k * bw + (bw * num) / den);
                        end
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, e, a);
        end
    endtask

    initial begin
        fail_count = 0;
        pending = 0;
        checked = 0;
        crossings = 0;
    end

    always @(posedge aclk) begin
        grid_result_t want;
        if (!aresetn) begin
            bw_x = 128;
            bw_y = 512;
            bw_z = 333;
            surface = 0;
            threshold = 508;
            nx_reg = 128;
            ny_reg = 32;
            nz_reg = 32;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (dgif_pkg::cfg_reg_t'(cfg_index))
                    dgif_pkg::CFG_BW_X:    bw_x = cfg_data[15:0];
                    dgif_pkg::CFG_BW_Y:    bw_y = cfg_data[15:0];
                    dgif_pkg::CFG_BW_Z:    bw_z = cfg_data[15:0];
                    dgif_pkg::CFG_SURFACE: surface = cfg_data[15:0];
                    dgif_pkg::CFG_THRESH:  threshold = cfg_data[23:0];
                    dgif_pkg::CFG_NX:      nx_reg = cfg_data[7:0];
                    dgif_pkg::CFG_NY:      ny_reg = cfg_data[5:0];
                    dgif_pkg::CFG_NZ:      nz_reg = cfg_data[5:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want = bin_or_scan(dgif_pkg::cmd_code_t'(s_tuser), s_tdata);
                column_results.insert(column_results.size(), want);
            end
            if (m_tvalid && m_tready) begin
                if (column_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result beat with nothing expected, got %h", $time, m_tdata);
                end else begin
                    want = column_results.pop_front();
                    check_field("dropped", want.dropped, m_tdata[0]);
                    check_field("left_valid", want.left_valid, m_tdata[1]);
                    check_field("left_position", want.left_position, m_tdata[17:2]);
                    check_field("right_valid", want.right_valid, m_tdata[18]);
                    check_field("right_position", want.right_position, m_tdata[34:19]);
                    checked++;
                    crossings += want.left_valid + want.right_valid;
                end
            end
        end
        pending = column_results.size();
    end

endmodule

/* verif/density_grid_interface_finder_unit_tb.sv */
`timescale 1ns / 1ps

module density_grid_interface_finder_unit_tb;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [dgif_pkg::S_DATA_W-1:0]  s_tdata;
    logic [dgif_pkg::S_USER_W-1:0]  s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [dgif_pkg::M_DATA_W-1:0]  m_tdata;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [dgif_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [dgif_pkg::CFG_DAT_W-1:0] cfg_data;

    int fail_count, pending, checked, crossings;
    int items_sent;
    bit long_hold;

    int unsigned cfg_val [8];

    density_grid_interface_finder_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    density_grid_interface_finder_unit_chk chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending),
        .checked(checked), .crossings(crossings)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // receiver: random back-pressure, plus one long hold on request
    initial begin
        int r, n;
        m_tready = 0;
        forever begin
            if (long_hold) begin
                @(negedge aclk) m_tready = 0;
                repeat (600) @(negedge aclk);
                long_hold = 0;
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                n = $urandom_range(1, 20);
                @(negedge aclk) m_tready = 1;
            end else if (r < 95) begin
                n = $urandom_range(1, 3);
                @(negedge aclk) m_tready = 0;
            end else begin
                n = $urandom_range(20, 80);
                @(negedge aclk) m_tready = 0;
            end
            repeat (n - 1) @(negedge aclk);
        end
    end

    task automatic send_beat(dgif_pkg::cmd_code_t cmd, bit [15:0] px, bit [15:0] py,
                             bit [15:0] pz, bit [4:0] qy, bit [4:0] qz);
        int r;
        r = $urandom_range(0, 99);
        if (r >= 70) begin
            @(negedge aclk) s_tvalid = 0;
            repeat ((r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40)) @(negedge aclk);
        end else begin
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = cmd;
        s_tdata = {6'b0, qz, qy, pz, py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // block drained before any register changes
    task automatic write_config;
        @(negedge aclk) s_tvalid = 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        for (int i = 0; i < 8; i++) begin
            @(negedge aclk);
            cfg_valid = 1;
            cfg_index = dgif_pkg::cfg_reg_t'(i);
            cfg_data = dgif_pkg::CFG_DAT_W'(cfg_val[i]);
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
        end
        @(negedge aclk) cfg_valid = 0;
    endtask

    task automatic random_items(int count);
        int unsigned bwx, bwy, bwz, nx, ny, nz, r;
        int unsigned bx, by, bz;
        bwx = (cfg_val[0] == 0) ? 1 : cfg_val[0];
        bwy = (cfg_val[1] == 0) ? 1 : cfg_val[1];
        bwz = (cfg_val[2] == 0) ? 1 : cfg_val[2];
        nx = (cfg_val[5] > 128) ? 128 : ((cfg_val[5] == 0) ? 1 : cfg_val[5]);
        ny = (cfg_val[6] > 32) ? 32 : ((cfg_val[6] == 0) ? 1 : cfg_val[6]);
        nz = (cfg_val[7] > 32) ? 32 : ((cfg_val[7] == 0) ? 1 : cfg_val[7]);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            bx = $urandom_range(0, nx - 1);
            by = $urandom_range(0, ny - 1);
            bz = $urandom_range(0, nz - 1);
            if (r < 70)
                send_beat(dgif_pkg::CMD_ADD, 16'(bx * bwx + $urandom_range(0, bwx - 1)),
                          16'(by * bwy + $urandom_range(0, bwy - 1)),
                          16'(cfg_val[3] + bz * bwz + $urandom_range(0, bwz - 1)),
                          5'($urandom), 5'($urandom));
            else if (r < 90)
                send_beat(dgif_pkg::CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                          5'(by), 5'(bz));
            else if (r < 94)
                send_beat(dgif_pkg::CMD_QUERY, 16'($urandom), 16'($urandom), 16'($urandom),
                          5'($urandom), 5'($urandom));
            else if (r < 98)
                send_beat(dgif_pkg::CMD_ADD, 16'($urandom), 16'($urandom), 16'($urandom),
                          5'($urandom), 5'($urandom));
            else
                send_beat(dgif_pkg::CMD_NONE, 16'($urandom), 16'($urandom), 16'($urandom),
                          5'($urandom), 5'($urandom));
        end
    endtask

    initial begin
        int unsigned nx;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = dgif_pkg::CMD_CLEAR;
        cfg_valid = 0;
        cfg_index = dgif_pkg::CFG_BW_X;
        cfg_data = '0;
        items_sent = 0;
        long_hold = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk) aresetn = 1;

        // defaults: extremes, unused command, a two-sided profile in column (0,0)
        send_beat(dgif_pkg::CMD_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F, 5'h1F);
        send_beat(dgif_pkg::CMD_QUERY, '0, '0, '0, '0, '0);
        send_beat(dgif_pkg::CMD_QUERY, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F, 5'h1F);
        send_beat(dgif_pkg::CMD_ADD, '0, '0, '0, '0, '0);
        send_beat(dgif_pkg::CMD_ADD, 16'hFFFF, '0, '0, '0, '0);
        send_beat(dgif_pkg::CMD_ADD, '0, 16'hFFFF, '0, '0, '0);
        send_beat(dgif_pkg::CMD_ADD, '0, '0, 16'hFFFF, '0, '0);
        for (int b = 62; b <= 65; b++) begin
            send_beat(dgif_pkg::CMD_ADD, 16'(b * 128 + 5), 16'd3, 16'd7, '0, '0);
            send_beat(dgif_pkg::CMD_ADD, 16'(b * 128 + 127), 16'd511, 16'd332, '0, '0);
        end
        send_beat(dgif_pkg::CMD_ADD, 16'(66 * 128), '0, '0, '0, '0);
        send_beat(dgif_pkg::CMD_QUERY, '0, '0, '0, '0, '0);
        send_beat(dgif_pkg::CMD_QUERY, '0, '0, '0, 5'd31, 5'd0);
        send_beat(dgif_pkg::CMD_CLEAR, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'h1F, 5'h1F);
        send_beat(dgif_pkg::CMD_QUERY, '0, '0, '0, '0, '0);

        for (int p = 1; p <= 12; p++) begin
            case (p)
                1: cfg_val = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF,
                               8'hFF, 6'h3F, 6'h3F};
                2: cfg_val = '{0, 0, 0, 0, 0, 0, 0, 0};
                3: cfg_val = '{$urandom_range(1, 300), $urandom_range(1, 999),
                               $urandom_range(1, 999), $urandom_range(0, 999),
                               $urandom_range(256, 600), 2, 1, 1};
                default: begin
                    nx = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 128)
                                                     : $urandom_range(2, 16);
                    cfg_val = '{$urandom_range(1, 65535 / nx), $urandom_range(1, 9000),
                                $urandom_range(1, 9000), $urandom_range(0, 3000),
                                256 * $urandom_range(1, 5) + $urandom_range(0, 255),
                                nx, $urandom_range(1, 3), $urandom_range(1, 3)};
                end
            endcase
            write_config();
            if (p == 4 || p == 8)
                send_beat(dgif_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
                          5'($urandom), 5'($urandom));
            if (p == 5) long_hold = 1;
            random_items(160);
        end

        @(negedge aclk) s_tvalid = 0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (400) @(posedge aclk);
        $display("%0d beats in over 13 register settings, %0d results checked",
                 items_sent, checked);
        $display("%0d interface crossings predicted and compared", crossings);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/dgif_pkg.sv
hw/rtl/dgif_divider.sv
hw/rtl/dgif_datapath.sv
hw/rtl/dgif_ctrl.sv
hw/rtl/density_grid_interface_finder_unit.sv
verif/density_grid_interface_finder_unit_chk.sv
verif/density_grid_interface_finder_unit_tb.sv
